// ===== src/sbmse_pkg.sv =====
// shared constants and types for the shifted block mean squared error block
`default_nettype none
package sbmse_pkg;

    localparam int COORD_BITS = 13;
    localparam int FRAC_BITS  = 8;

    localparam int PIX_W      = 8;
    localparam int SQ_W       = 2 * PIX_W;
    localparam int ERR_W      = SQ_W + 2;
    localparam int SUM_W      = 44;
    localparam int COUNT_W    = 27;
    localparam int MEAN_W     = 26;
    localparam int SIZE_W     = 14;
    localparam int SHIFT_W    = 18;
    localparam int SHIFT_FRAC = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SHIFT_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y      = 2'd3;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 14'd8192;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = '0;

    localparam int OUT_DATA_W = ((MEAN_W + COUNT_W + 7) / 8) * 8;

    typedef struct packed {
        logic adv;
        logic hit;
        logic last;
    } acc_ctl_t;

    typedef struct packed {
        logic               load;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } win_res_t;

endpackage
`default_nettype wire

// ===== src/shifted_block_mean_squared_error.sv =====
// top level: shifted block mean squared error over a reference window
//
//  channel  dir  handshake                        payload
//  s_axis   in   s_axis_tvalid / s_axis_tready    tdata pixel request, tlast window_end
//  m_axis   out  m_axis_tvalid / m_axis_tready    tdata mean and count, tuser no_overlap
//  cfg      in   cfg_valid / cfg_ready            cfg_index, cfg_data
//
//  one pixel per cycle unless stalled; lanes and bounds register in one stage,
//  accumulation in the next; a window end hands the sums to the serial divider
//  (52-bit quotient); next-window pixels flow on during the division; only the last
//  pixel waits for the divider, which frees once its result sits in the output register
//  aresetn is synchronous, active low; registers return to 8192 x 8192, zero shift
`default_nettype none
module shifted_block_mean_squared_error #(
    parameter int COORD_BITS = sbmse_pkg::COORD_BITS,
    parameter int FRAC_BITS  = sbmse_pkg::FRAC_BITS
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // x_pos, y_pos, ref_red, ref_green, ref_blue, flt_red, flt_green, flt_blue
    input  wire logic [((2*COORD_BITS+6*sbmse_pkg::PIX_W+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                                   s_axis_tlast,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // mean_error, pixel_count
    output logic [sbmse_pkg::OUT_DATA_W-1:0]            m_axis_tdata,
    // no_overlap
    output logic                                        m_axis_tuser,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [sbmse_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [sbmse_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int PW    = sbmse_pkg::PIX_W;
    localparam int SZW   = sbmse_pkg::SIZE_W;
    localparam int SHW   = sbmse_pkg::SHIFT_W;
    localparam int OFF_Y = COORD_BITS;
    localparam int OFF_P = 2 * COORD_BITS;

    logic [SZW-1:0] width_reg, height_reg;
    logic [SHW-1:0] shift_x_reg, shift_y_reg;

    logic s1_valid_reg, s1_hit_reg, s1_last_reg;
    logic in_x, in_y;
    logic s1_adv, load_en, div_busy;
    logic [sbmse_pkg::SQ_W-1:0] sq_red, sq_green, sq_blue;
    sbmse_pkg::acc_ctl_t ctl;
    sbmse_pkg::win_res_t win;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= sbmse_pkg::SIZE_RESET;
            height_reg  <= sbmse_pkg::SIZE_RESET;
            shift_x_reg <= sbmse_pkg::SHIFT_RESET;
            shift_y_reg <= sbmse_pkg::SHIFT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sbmse_pkg::REG_IMAGE_WIDTH:  width_reg   <= cfg_data[SZW-1:0];
                sbmse_pkg::REG_IMAGE_HEIGHT: height_reg  <= cfg_data[SZW-1:0];
                sbmse_pkg::REG_SHIFT_X:      shift_x_reg <= cfg_data;
                sbmse_pkg::REG_SHIFT_Y:      shift_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s1_adv        = s1_valid_reg && !(s1_last_reg && div_busy);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign load_en       = s_axis_tvalid && s_axis_tready;

    sbmse_bounds #(.COORD_BITS(COORD_BITS)) u_bounds_x (
        .pos       (s_axis_tdata[COORD_BITS-1:0]),
        .shift     (shift_x_reg),
        .size      (width_reg),
        .in_bounds (in_x)
    );

    sbmse_bounds #(.COORD_BITS(COORD_BITS)) u_bounds_y (
        .pos       (s_axis_tdata[OFF_Y +: COORD_BITS]),
        .shift     (shift_y_reg),
        .size      (height_reg),
        .in_bounds (in_y)
    );

    sbmse_lane u_lane_red (
        .aclk    (aclk),
        .load    (load_en),
        .ref_pix (s_axis_tdata[OFF_P +: PW]),
        .flt_pix (s_axis_tdata[OFF_P + 3*PW +: PW]),
        .sq_out  (sq_red)
    );

    sbmse_lane u_lane_green (
        .aclk    (aclk),
        .load    (load_en),
        .ref_pix (s_axis_tdata[OFF_P + PW +: PW]),
        .flt_pix (s_axis_tdata[OFF_P + 4*PW +: PW]),
        .sq_out  (sq_green)
    );

    sbmse_lane u_lane_blue (
        .aclk    (aclk),
        .load    (load_en),
        .ref_pix (s_axis_tdata[OFF_P + 2*PW +: PW]),
        .flt_pix (s_axis_tdata[OFF_P + 5*PW +: PW]),
        .sq_out  (sq_blue)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_hit_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
        end else if (load_en) begin
            s1_valid_reg <= 1'b1;
            s1_hit_reg   <= in_x && in_y;
            s1_last_reg  <= s_axis_tlast;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        ctl.adv  = s1_adv;
        ctl.hit  = s1_hit_reg;
        ctl.last = s1_last_reg;
    end

    sbmse_accum u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .sq_red   (sq_red),
        .sq_green (sq_green),
        .sq_blue  (sq_blue),
        .win      (win)
    );

    sbmse_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .win           (win),
        .busy          (div_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

// ===== src/sbmse_lane.sv =====
// one color lane: registered squared absolute difference
`default_nettype none
module sbmse_lane (
    input  wire logic                          aclk,
    input  wire logic                          load,
    input  wire logic [sbmse_pkg::PIX_W-1:0]   ref_pix,
    input  wire logic [sbmse_pkg::PIX_W-1:0]   flt_pix,
    output logic      [sbmse_pkg::SQ_W-1:0]    sq_out
);

    logic [sbmse_pkg::PIX_W-1:0] diff;
    logic [sbmse_pkg::SQ_W-1:0]  sq_reg;
    logic [sbmse_pkg::SQ_W-1:0]  sq_next;

    always_comb begin
        diff    = (ref_pix > flt_pix) ? (ref_pix - flt_pix) : (flt_pix - ref_pix);
        sq_next = diff * diff;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sq_reg <= sq_next;
        end
    end

    assign sq_out = sq_reg;

endmodule
`default_nettype wire

// ===== src/sbmse_bounds.sv =====
// one axis: shifted, rounded coordinate tested against the image size
`default_nettype none
module sbmse_bounds #(
    parameter int COORD_BITS = sbmse_pkg::COORD_BITS
) (
    input  wire logic [COORD_BITS-1:0]          pos,
    input  wire logic [sbmse_pkg::SHIFT_W-1:0]  shift,
    input  wire logic [sbmse_pkg::SIZE_W-1:0]   size,
    output logic                                in_bounds
);

    localparam int SF   = sbmse_pkg::SHIFT_FRAC;
    localparam int SW   = sbmse_pkg::SHIFT_W;
    localparam int BASE = (COORD_BITS + SF + 1 > SW) ? COORD_BITS + SF + 1 : SW;
    localparam int PW   = BASE + 2;
    localparam int CW   = (PW - SF > sbmse_pkg::SIZE_W) ? PW - SF : sbmse_pkg::SIZE_W;
    localparam logic signed [PW-1:0] HALF    = PW'(1 << (SF - 1));
    localparam logic signed [PW-1:0] NEG_LIM = -PW'((1 << SF) - 1);

    logic signed [PW-1:0] pos_ext;
    logic signed [PW-1:0] shift_ext;
    logic signed [PW-1:0] p;
    logic [CW-1:0]        coord;
    logic [CW-1:0]        size_ext;

    always_comb begin
        pos_ext   = signed'(PW'({pos, {SF{1'b0}}}));
        shift_ext = signed'({{(PW - SW){shift[SW-1]}}, shift});
        p         = pos_ext + shift_ext + HALF;
        coord     = CW'(p[PW-1:SF]);
        size_ext  = CW'(size);
        if (p < NEG_LIM) begin
            in_bounds = 1'b0;
        end else if (p[PW-1]) begin
            in_bounds = (size != '0);
        end else begin
            in_bounds = (coord < size_ext);
        end
    end

endmodule
`default_nettype wire

// ===== src/sbmse_accum.sv =====
// lane merge and saturating window accumulation
`default_nettype none
module sbmse_accum (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire sbmse_pkg::acc_ctl_t         ctl,
    input  wire logic [sbmse_pkg::SQ_W-1:0]  sq_red,
    input  wire logic [sbmse_pkg::SQ_W-1:0]  sq_green,
    input  wire logic [sbmse_pkg::SQ_W-1:0]  sq_blue,
    output sbmse_pkg::win_res_t              win
);

    localparam int SUM_W   = sbmse_pkg::SUM_W;
    localparam int COUNT_W = sbmse_pkg::COUNT_W;
    localparam int ERR_W   = sbmse_pkg::ERR_W;

    logic [SUM_W-1:0]   sum_reg,   sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ERR_W-1:0]   err;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_upd;
    logic [COUNT_W-1:0] count_upd;

    always_comb begin
        err     = ERR_W'(sq_red) + ERR_W'(sq_green) + ERR_W'(sq_blue);
        sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(err);
        if (ctl.hit) begin
            sum_upd   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            count_upd = (&count_reg) ? count_reg : count_reg + 1'b1;
        end else begin
            sum_upd   = sum_reg;
            count_upd = count_reg;
        end
        sum_next   = sum_reg;
        count_next = count_reg;
        win.load   = 1'b0;
        win.sum    = sum_upd;
        win.count  = count_upd;
        if (ctl.adv) begin
            if (ctl.last) begin
                win.load   = 1'b1;
                sum_next   = '0;
                count_next = '0;
            end else begin
                sum_next   = sum_upd;
                count_next = count_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/sbmse_div.sv =====
// bit-serial restoring divider for the window mean, with output register
`default_nettype none
module sbmse_div #(
    parameter int FRAC_BITS = sbmse_pkg::FRAC_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire sbmse_pkg::win_res_t                 win,
    output logic                                     busy,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [sbmse_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    output logic                                     m_axis_tuser
);

    localparam int COUNT_W = sbmse_pkg::COUNT_W;
    localparam int MEAN_W  = sbmse_pkg::MEAN_W;
    localparam int N       = sbmse_pkg::SUM_W + FRAC_BITS;
    localparam int CNT_W   = $clog2(N);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(N - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [N-1:0]       dq_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] div_reg;
    logic [COUNT_W:0]   rem_shift;
    logic [COUNT_W:0]   rem_sub;
    logic               q_bit;
    logic [MEAN_W-1:0]  mean;
    logic               out_load;
    logic               m_valid_reg;
    logic [MEAN_W-1:0]  m_mean_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic               m_none_reg;

    always_comb begin
        rem_shift = {rem_reg, dq_reg[N-1]};
        rem_sub   = rem_shift - {1'b0, div_reg};
        q_bit     = (rem_shift >= {1'b0, div_reg});
        mean      = (|dq_reg[N-1:MEAN_W]) ? '1 : dq_reg[MEAN_W-1:0];
        out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (win.load) state_next = ST_RUN;
            ST_RUN:  if (cnt_reg == LAST_STEP) state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && win.load) begin
            dq_reg  <= N'(win.sum) << FRAC_BITS;
            rem_reg <= '0;
            div_reg <= win.count;
            cnt_reg <= '0;
        end else if (state_reg == ST_RUN) begin
            dq_reg  <= {dq_reg[N-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (out_load) begin
            m_none_reg  <= (div_reg == '0);
            m_count_reg <= div_reg;
            m_mean_reg  <= (div_reg == '0) ? '0 : mean;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = sbmse_pkg::OUT_DATA_W'({m_count_reg, m_mean_reg});
    assign m_axis_tuser  = m_none_reg;

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        win.load |-> state_reg == ST_IDLE)
        else $error("window handed over while divider busy");

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && cnt_reg == LAST_STEP) |=> state_reg == ST_DONE)
        else $error("divider did not finish after last step");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == '0)
        else $error("no-overlap result carries nonzero data");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> m_count_reg != '0)
        else $error("overlap result with zero count");

endmodule
`default_nettype wire
